FILE: rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// shared types and constants of the masked byte pattern search
// ----------------------------------------------------------------------------
package mbps_pkg;

    // default sizes
    localparam int MAX_PATTERN_DEF = 64;
    localparam int OFFSET_BITS_DEF = 48;

    // fixed field widths
    localparam int BYTE_W    = 8;
    localparam int INDEX_W   = 6;
    localparam int PLEN_W    = 7;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // register indexes (byte address is 8 * index)
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [1:0] REG_START_OFFSET   = 2'd1;
    localparam logic [1:0] REG_END_OFFSET     = 2'd2;

    // broadcast from the top level to every cell of the chain
    typedef struct packed {
        logic              load;       // write the selected cell
        logic              shift;      // advance the chain by one data byte
        logic [BYTE_W-1:0] byte_value; // pattern byte or stream byte
        logic              care;       // compare flag for a load
    } mbps_bcast_t;

endpackage

FILE: rtl/masked_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search
// wildcard byte pattern search over a byte stream with absolute offsets
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-----------------------------------------
//  in      | input     | in_valid/in_stall | op, pattern_index, byte_value, care
//  out     | output    | out_valid/out_stall | found, first_offset, last_offset, finished
//  cfg     | input     | apb psel/penable | pattern_length, start_offset, end_offset
//
//  one transaction per cycle while in_stall is low; a data byte's result appears in
//  the cycle after it is taken, set by the output register
//  a load transaction gives no result
//  reset clears the match chain, byte count, offsets and done flag; pattern
//  entries stay undefined until loaded
//  in_stall rises while a result sits in the output register and out_stall is high
// ----------------------------------------------------------------------------
module masked_byte_pattern_search #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            op,
    input  logic [mbps_pkg::INDEX_W-1:0]    pattern_index,
    input  logic [mbps_pkg::BYTE_W-1:0]     byte_value,
    input  logic                            care,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            found,
    output logic [OFFSET_BITS-1:0]          first_offset,
    output logic [OFFSET_BITS-1:0]          last_offset,
    output logic                            finished,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mbps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mbps_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CL_W  = ((LEN_W > PLEN_W) ? LEN_W : PLEN_W) + 1;

    // configuration registers
    logic [PLEN_W-1:0]      pattern_length_reg, pattern_length_next;
    logic [OFFSET_BITS-1:0] start_offset_reg,   start_offset_next;
    logic [OFFSET_BITS-1:0] end_offset_reg,     end_offset_next;

    // scan state
    logic [OFFSET_BITS-1:0] bytes_seen_reg, bytes_seen_next;
    logic [OFFSET_BITS-1:0] offset_reg,     offset_next;
    logic                   scan_done_reg,  scan_done_next;

    // output register
    logic                   out_valid_reg,    out_valid_next;
    logic                   found_reg,        found_next;
    logic [OFFSET_BITS-1:0] first_offset_reg, first_offset_next;
    logic [OFFSET_BITS-1:0] last_offset_reg,  last_offset_next;
    logic                   finished_reg,     finished_next;

    logic                   in_take;
    logic                   out_take;
    logic                   data_take;
    logic                   scan_take;
    logic                   cfg_wr;
    logic [1:0]             cfg_idx;
    logic                   start_wr;
    logic [LEN_W-1:0]       len_eff;
    logic [IDX_W-1:0]       len_last;
    logic                   at_end;
    logic                   hit;
    logic [OFFSET_BITS-1:0] offset_inc;
    mbps_bcast_t            bcast;

    // ---------------- handshakes ----------------
    // a result waiting under stall blocks the next transaction
    assign in_stall  = out_valid_reg && out_stall;
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign data_take = in_take && (op == OP_DATA);
    // bytes after the end give a result but leave the state alone
    assign scan_take = data_take && !scan_done_reg;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[APB_ADDR_W-1:3];
    assign start_wr = cfg_wr && (cfg_idx == REG_START_OFFSET);

    always_comb
    begin
        pattern_length_next = pattern_length_reg;
        start_offset_next   = start_offset_reg;
        end_offset_next     = end_offset_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_PATTERN_LENGTH: pattern_length_next = pwdata[PLEN_W-1:0];
                REG_START_OFFSET:   start_offset_next   = pwdata[OFFSET_BITS-1:0];
                REG_END_OFFSET:     end_offset_next     = pwdata[OFFSET_BITS-1:0];
                default:            ; // addresses past the list are ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_PATTERN_LENGTH: prdata = APB_DATA_W'(pattern_length_reg);
            REG_START_OFFSET:   prdata = APB_DATA_W'(start_offset_reg);
            REG_END_OFFSET:     prdata = APB_DATA_W'(end_offset_reg);
            default:            prdata = '0;
        endcase
    end

    // ---------------- effective pattern length ----------------
    // zero acts as one, anything above the chain length as the full chain
    always_comb
    begin
        priority if (pattern_length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (CL_W'(pattern_length_reg) > CL_W'(MAX_PATTERN))
        begin
            len_eff = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_eff = LEN_W'(pattern_length_reg);
        end
    end

    assign len_last = IDX_W'(len_eff - LEN_W'(1));

    // ---------------- chain broadcast ----------------
    always_comb
    begin
        bcast.load       = in_take && (op == OP_LOAD);
        bcast.shift      = scan_take;
        bcast.byte_value = byte_value;
        bcast.care       = care;
    end

    mbps_chain #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W),
        .IDX_W       (IDX_W)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .bcast      (bcast),
        .load_index (pattern_index),
        .len_eff    (len_eff),
        .len_last   (len_last),
        .hit        (hit)
    );

    // ---------------- offset tracking ----------------
    // offset_reg = start_offset + bytes_seen unless start_wr and scan_take coincide
    assign offset_inc = offset_reg + OFFSET_BITS'(1);
    assign at_end     = (offset_reg >= end_offset_reg);

    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        offset_next     = offset_reg;
        scan_done_next  = scan_done_reg;
        if (scan_take)
        begin
            bytes_seen_next = bytes_seen_reg + OFFSET_BITS'(1);
            offset_next     = offset_inc;
            if (at_end)
            begin
                scan_done_next = 1'b1;
            end
        end
        // a new start rebases the running offset on the bytes already seen
        if (start_wr)
        begin
            offset_next = pwdata[OFFSET_BITS-1:0] + bytes_seen_reg;
        end
    end

    // ---------------- result register ----------------
    always_comb
    begin
        out_valid_next    = out_valid_reg;
        found_next        = found_reg;
        first_offset_next = first_offset_reg;
        last_offset_next  = last_offset_reg;
        finished_next     = finished_reg;
        if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        if (data_take)
        begin
            out_valid_next = 1'b1;
            if (scan_done_reg)
            begin
                found_next        = 1'b0;
                first_offset_next = '0;
                last_offset_next  = '0;
                finished_next     = 1'b1;
            end
            else
            begin
                found_next        = hit;
                first_offset_next = hit ? (offset_reg - OFFSET_BITS'(len_last)) : '0;
                last_offset_next  = hit ? offset_reg : '0;
                finished_next     = at_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= PLEN_W'(1);
            start_offset_reg   <= '0;
            end_offset_reg     <= '0;
            bytes_seen_reg     <= '0;
            offset_reg         <= '0;
            scan_done_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            pattern_length_reg <= pattern_length_next;
            start_offset_reg   <= start_offset_next;
            end_offset_reg     <= end_offset_next;
            bytes_seen_reg     <= bytes_seen_next;
            offset_reg         <= offset_next;
            scan_done_reg      <= scan_done_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // payload of the result register needs no reset
    always_ff @(posedge clk)
    begin
        found_reg        <= found_next;
        first_offset_reg <= first_offset_next;
        last_offset_reg  <= last_offset_next;
        finished_reg     <= finished_next;
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign first_offset = first_offset_reg;
    assign last_offset  = last_offset_reg;
    assign finished     = finished_reg;

    // ---------------- assertions ----------------
    // the scan stays finished until reset
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done_reg |=> scan_done_reg)
        else $error("scan done flag cleared");

    // finishing is reported with the byte that reached the end
    a_done_report: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(scan_done_reg) |-> (out_valid_reg && finished_reg))
        else $error("end of scan not reported");

    // the running offset steps by one per scanned byte
    a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_take && !start_wr) |=> (offset_reg == $past(offset_inc)))
        else $error("offset did not advance by one");

endmodule

FILE: rtl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// one pattern position: stored byte, compare flag and partial match bit
// ----------------------------------------------------------------------------
module mbps_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  mbps_pkg::mbps_bcast_t bcast,
    input  logic                sel,
    input  logic                active,
    input  logic                prev_match,
    output logic                match_next,
    output logic                match_q
);
    import mbps_pkg::*;

    logic [BYTE_W-1:0] pat_byte_reg;
    logic              care_reg;
    logic              match_reg;

    // pattern storage, undefined until loaded
    always_ff @(posedge clk)
    begin
        if (bcast.load && sel)
        begin
            pat_byte_reg <= bcast.byte_value;
            care_reg     <= bcast.care;
        end
    end

    assign match_next = prev_match && active
                        && (!care_reg || (pat_byte_reg == bcast.byte_value));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (bcast.shift)
        begin
            match_reg <= match_next;
        end
    end

    assign match_q = match_reg;

endmodule

FILE: rtl/mbps_chain.sv
// ----------------------------------------------------------------------------
// mbps_chain
// row of pattern cells forming the shift-and match chain
// ----------------------------------------------------------------------------
module mbps_chain #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1),
    parameter int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mbps_pkg::mbps_bcast_t        bcast,
    input  logic [mbps_pkg::INDEX_W-1:0] load_index,
    input  logic [LEN_W-1:0]             len_eff,
    input  logic [IDX_W-1:0]             len_last,
    output logic                         hit
);
    import mbps_pkg::*;

    localparam int CMP_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

    logic [MAX_PATTERN-1:0] prev_vec;
    logic [MAX_PATTERN-1:0] match_next_vec;
    logic [MAX_PATTERN-1:0] match_q_vec;

    genvar i;
    generate
        for (i = 0; i < MAX_PATTERN; i++)
        begin : g_cell
            logic sel;
            logic active;

            assign sel    = (CMP_W'(load_index) == CMP_W'(i));
            assign active = (LEN_W'(i) < len_eff);

            // position 0 always starts a new candidate
            if (i == 0)
            begin : g_head
                assign prev_vec[i] = 1'b1;
            end
            else
            begin : g_link
                assign prev_vec[i] = match_q_vec[i-1];
            end

            mbps_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .bcast      (bcast),
                .sel        (sel),
                .active     (active),
                .prev_match (prev_vec[i]),
                .match_next (match_next_vec[i]),
                .match_q    (match_q_vec[i])
            );
        end
    endgenerate

    // the last position in use completes a match
    assign hit = match_next_vec[len_last];

    // chain holds when no data byte is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !bcast.shift |=> $stable(match_q_vec))
        else $error("match chain moved without a data byte");

    // a reported hit leaves the last position set
    a_hit_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (bcast.shift && hit) |=> match_q_vec[$past(len_last)])
        else $error("hit not stored in the chain");

    // load and shift come from different operations
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(bcast.load && bcast.shift))
        else $error("load and shift in the same cycle");

endmodule

FILE: verif/masked_byte_pattern_search_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_test
// self-checking bench for the masked byte pattern search
//
// a behavioral shift-and scanner runs beside the block and predicts one result
// per data byte; results are checked in order, field by field. directed
// transactions cover wildcards, loads during a scan and the length limits, a
// long pattern straddles the offset wrap, random phases feed pattern instances
// mixed with noise under random gaps and stalls, and the last phase drives the
// scan past its end offset
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_test;

    import mbps_pkg::*;

    localparam int MAX_PAT = MAX_PATTERN_DEF;
    localparam int OFF_W   = OFFSET_BITS_DEF;
    localparam logic [OFF_W-1:0] OFF_MAX = '1;

    // cycles without any accepted transaction before the run is abandoned
    localparam int IDLE_LIMIT = 2000;

    // expected content of one result transaction
    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] first_offset;
        logic [OFF_W-1:0] last_offset;
        logic             finished;
    } scan_result_t;

    // dut ports; the inputs driven by the bench are known from time zero
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  op = OP_LOAD;
    logic [INDEX_W-1:0]    pattern_index = '0;
    logic [BYTE_W-1:0]     byte_value = '0;
    logic                  care = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  found;
    logic [OFF_W-1:0]      first_offset;
    logic [OFF_W-1:0]      last_offset;
    logic                  finished;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // scanner state mirrored on the bench side, reset values as in the block
    logic [BYTE_W-1:0]  pat_byte [MAX_PAT];
    logic               pat_care [MAX_PAT];
    logic [MAX_PAT-1:0] match_chain = '0;
    logic [OFF_W-1:0]   bytes_taken = '0;
    logic               scan_over = 1'b0;
    logic [PLEN_W-1:0]  cfg_length = PLEN_W'(1);
    logic [OFF_W-1:0]   cfg_start = '0;
    logic [OFF_W-1:0]   cfg_end = '0;

    // results still owed by the block, oldest first
    scan_result_t pending_results [$];
    scan_result_t head_result;

    int mismatch_count = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;

    // when set, the sender never idles / the receiver never stalls
    logic source_steady = 1'b0;
    logic sink_steady = 1'b0;

    masked_byte_pattern_search DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .pattern_index (pattern_index),
        .byte_value    (byte_value),
        .care          (care),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .first_offset  (first_offset),
        .last_offset   (last_offset),
        .finished      (finished),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // out-of-range lengths clamp to 1..MAX_PAT
    function automatic int eff_len(input logic [PLEN_W-1:0] len_val);
        if (len_val == 0)
            return 1;
        if (len_val > MAX_PAT)
            return MAX_PAT;
        return int'(len_val);
    endfunction

    // one data byte through the shift-and chain
    function automatic scan_result_t scan_byte(input logic [BYTE_W-1:0] b);
        scan_result_t     r;
        int               len;
        int               i;
        logic [OFF_W-1:0] off;
        logic [MAX_PAT-1:0] nxt;
        r = '0;
        if (scan_over)
        begin
            // past the end: nothing moves, only the done flag shows
            r.finished = 1'b1;
            return r;
        end
        len = eff_len(cfg_length);
        off = cfg_start + bytes_taken;
        nxt = {match_chain[MAX_PAT-2:0], 1'b1};
        for (i = 0; i < MAX_PAT; i++)
        begin
            if (!(i < len && (!pat_care[i] || pat_byte[i] == b)))
                nxt[i] = 1'b0;
        end
        match_chain = nxt;
        if (match_chain[len-1])
        begin
            r.found = 1'b1;
            r.first_offset = off - OFF_W'(len - 1);
            r.last_offset = off;
        end
        bytes_taken = bytes_taken + OFF_W'(1);
        if (off >= cfg_end)
        begin
            scan_over = 1'b1;
            r.finished = 1'b1;
        end
        return r;
    endfunction

    // mostly short idles, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // a byte that fits pattern position j; wildcards get any value
    function automatic logic [BYTE_W-1:0] instance_byte(input int j);
        if (pat_care[j])
            return pat_byte[j];
        return BYTE_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one input transaction; returns at the edge where it is taken
    task automatic send_item(input logic op_v, input logic [INDEX_W-1:0] idx_v,
                             input logic [BYTE_W-1:0] byte_v, input logic care_v);
        int gap;
        gap = source_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= op_v;
        pattern_index <= idx_v;
        byte_value    <= byte_v;
        care          <= care_v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (op_v == OP_LOAD)
        begin
            // loads act from the next data byte on
            pat_byte[idx_v] = byte_v;
            pat_care[idx_v] = care_v;
        end
        else
        begin
            pending_results.push_back(scan_byte(byte_v));
        end
    endtask

    task automatic send_load(input int idx_v, input logic [BYTE_W-1:0] byte_v,
                             input logic care_v);
        send_item(OP_LOAD, INDEX_W'(idx_v), byte_v, care_v);
    endtask

    // index and care are don't-care for data, so they carry noise
    task automatic send_data(input logic [BYTE_W-1:0] byte_v);
        send_item(OP_DATA, INDEX_W'($urandom), byte_v, 1'(($urandom)));
    endtask

    // stop sending and let every owed result come out, then let a load settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb write: setup and access phases, then the bus returns to idle
    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PATTERN_LENGTH: cfg_length = value[PLEN_W-1:0];
            REG_START_OFFSET:   cfg_start  = value[OFF_W-1:0];
            REG_END_OFFSET:     cfg_end    = value[OFF_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // short pattern with a wildcard, a load inside a scan, length zero
    task automatic test_directed_match();
        write_reg(REG_END_OFFSET, APB_DATA_W'(OFF_MAX));
        write_reg(REG_START_OFFSET, '0);
        write_reg(REG_PATTERN_LENGTH, APB_DATA_W'(4));
        // pattern 00 ?? ff 5a
        send_load(0, 8'h00, 1'b1);
        send_load(1, 8'hff, 1'b0);
        send_load(2, 8'hff, 1'b1);
        send_load(3, 8'h5a, 1'b1);
        // hits with the wildcard taking 00 and 77, then a near miss
        send_data(8'h00);
        send_data(8'h00);
        send_data(8'hff);
        send_data(8'h5a);
        send_data(8'h00);
        send_data(8'h77);
        send_data(8'hff);
        send_data(8'h5a);
        send_data(8'h00);
        send_data(8'h33);
        send_data(8'hfe);
        send_data(8'h5a);
        // change position 2 with a match already under way
        send_data(8'h00);
        send_data(8'h10);
        send_load(2, 8'hfe, 1'b1);
        send_data(8'hfe);
        send_data(8'h5a);
        send_load(63, 8'hff, 1'b1);
        drain_results();
        // zero length scans as one byte
        write_reg(REG_PATTERN_LENGTH, '0);
        send_data(8'h00);
        send_data(8'h80);
        send_data(8'h00);
        drain_results();
    endtask

    // all 64 entries, clamped length, and a match straddling the offset wrap
    task automatic test_full_pattern();
        int j;
        for (j = 0; j < MAX_PAT; j++)
            send_load(j, BYTE_W'($urandom), $urandom_range(0, 3) != 0);
        drain_results();
        write_reg(REG_PATTERN_LENGTH, APB_DATA_W'(127));
        for (j = 0; j < 30; j++)
            send_data(instance_byte(j));
        drain_results();
        // next byte lands on offset zero; the chain survives the write
        write_reg(REG_START_OFFSET, APB_DATA_W'(OFF_W'(0) - bytes_taken));
        for (j = 30; j < MAX_PAT; j++)
            send_data(instance_byte(j));
        drain_results();
        write_reg(REG_PATTERN_LENGTH, APB_DATA_W'(MAX_PAT));
        write_reg(REG_START_OFFSET, APB_DATA_W'(OFF_MAX));
        for (j = 0; j < MAX_PAT; j++)
            send_data(instance_byte(j));
        for (j = 0; j < 10; j++)
            send_data(BYTE_W'($urandom));
        drain_results();
    endtask

    // phases of random settings; pattern instances, noise and stray loads
    task automatic test_random_scan();
        int               first_item;
        int               roll;
        int               eff;
        int               j;
        int               bad_pos;
        int               phase_items;
        int               phase_start;
        logic [PLEN_W-1:0] len_val;
        logic [OFF_W-1:0] target;
        logic [OFF_W-1:0] end_val;
        logic [63:0]      wide;
        logic [BYTE_W-1:0] b;
        first_item = items_sent;
        while (items_sent - first_item < 800)
        begin
            drain_results();
            roll = $urandom_range(0, 99);
            if (roll < 70)
                len_val = PLEN_W'($urandom_range(1, 6));
            else if (roll < 88)
                len_val = PLEN_W'($urandom_range(7, MAX_PAT));
            else if (roll < 94)
                len_val = '0;
            else
                len_val = PLEN_W'($urandom_range(MAX_PAT + 1, 127));
            eff = eff_len(len_val);
            phase_items = $urandom_range(40, 120);

            // offset of the phase's first byte; kept well below the end
            roll = $urandom_range(0, 99);
            if (roll < 50)
            begin
                wide = {$urandom, $urandom};
                target = wide[OFF_W-1:0];
                if (target > OFF_MAX - 8192)
                    target = target - 8192;
            end
            else if (roll < 80)
                target = OFF_W'($urandom_range(0, 200));
            else
                target = cfg_start + bytes_taken;
            if ($urandom_range(0, 3) == 0)
                end_val = target + OFF_W'(phase_items + MAX_PAT + $urandom_range(1, 5000));
            else
                end_val = OFF_MAX;

            source_steady = ($urandom_range(0, 4) == 0);
            sink_steady = ($urandom_range(0, 4) == 0);
            write_reg(REG_PATTERN_LENGTH, APB_DATA_W'(len_val));
            write_reg(REG_START_OFFSET, APB_DATA_W'(target - bytes_taken));
            write_reg(REG_END_OFFSET, APB_DATA_W'(end_val));

            // partial reload of the positions in use
            for (j = 0; j < eff; j++)
            begin
                if ($urandom_range(0, 1) == 1)
                    send_load(j, BYTE_W'($urandom), $urandom_range(0, 3) != 0);
            end

            phase_start = items_sent;
            while (items_sent - phase_start < phase_items)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                begin
                    // one instance, sometimes with a spoiled position
                    bad_pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, eff - 1) : -1;
                    for (j = 0; j < eff; j++)
                    begin
                        b = (j == bad_pos) ? BYTE_W'($urandom) : instance_byte(j);
                        send_data(b);
                    end
                end
                else if (roll < 90)
                begin
                    // noise, half of it drawn from the pattern's own bytes
                    if ($urandom_range(0, 1) == 1)
                        send_data(pat_byte[$urandom_range(0, eff - 1)]);
                    else
                        send_data(BYTE_W'($urandom));
                end
                else if (roll < 97)
                begin
                    send_load($urandom_range(0, MAX_PAT - 1), BYTE_W'($urandom),
                              1'(($urandom)));
                end
                else
                begin
                    // sender holds off until the block has caught up
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (pending_results.size() != 0);
                end
            end
        end
        source_steady = 1'b0;
        sink_steady = 1'b0;
        drain_results();
    endtask

    // start past the end: one byte scanned, then the scan stays done
    task automatic test_end_of_scan();
        int j;
        write_reg(REG_PATTERN_LENGTH, APB_DATA_W'(1));
        write_reg(REG_START_OFFSET, APB_DATA_W'(OFF_MAX));
        write_reg(REG_END_OFFSET, '0);
        send_data(instance_byte(0));
        for (j = 0; j < 8; j++)
        begin
            if (j == 3)
                send_load(0, BYTE_W'($urandom), 1'b0);
            else
                send_data(BYTE_W'($urandom));
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // receiver side
    // ------------------------------------------------------------------------

    // random stalls, with run lengths drawn from pick_gap
    always @(posedge clk)
    begin
        if (sink_steady)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 30)
        begin
            stall_left = pick_gap();
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(input string field_name, input logic [OFF_W-1:0] want_v,
                                   input logic [OFF_W-1:0] got_v);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field_name, want_v, got_v);
    endtask

    // every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result transaction with none expected, actual %0b %0h %0h %0b",
                         $time, found, first_offset, last_offset, finished);
            end
            else
            begin
                head_result = pending_results.pop_front();
                if (found !== head_result.found)
                    report_mismatch("found", OFF_W'(head_result.found), OFF_W'(found));
                if (first_offset !== head_result.first_offset)
                    report_mismatch("first_offset", head_result.first_offset, first_offset);
                if (last_offset !== head_result.last_offset)
                    report_mismatch("last_offset", head_result.last_offset, last_offset);
                if (finished !== head_result.finished)
                    report_mismatch("finished", OFF_W'(head_result.finished), OFF_W'(finished));
            end
        end
    end

    // watchdog: any accepted transaction on any port counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("masked_byte_pattern_search verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_match();
        test_full_pattern();
        test_random_scan();
        test_end_of_scan();

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("masked_byte_pattern_search verification clean");
        else
            $display("masked_byte_pattern_search verification failed");
        $finish;
    end

endmodule
